FILE: src/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");
// implication from antecedent to consequent in the same cycle
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`else
`define ASSERT_ALWAYS(name, clk, rst, prop)
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`endif
`endif

FILE: src/spst_pkg.sv
// Shared types and constants for the step pulse and segment timer core.
// No dependencies.
package spst_pkg;

   localparam int unsigned NUM_AXES_DEF       = 4;
   localparam int unsigned MIN_SEG_PERIOD_DEF = 60;
   localparam logic [31:0] WAKE_PERIOD_DEF    = 32'd120000;
   localparam logic [15:0] PULSE_FLOOR        = 16'd48;
   localparam logic [15:0] PULSE_TICKS_RST    = 16'd120;

   typedef enum logic [2:0] {
      REQ_TICK       = 3'd0,
      REQ_PULSE      = 3'd1,
      REQ_SET_PERIOD = 3'd2,
      REQ_WAKE       = 3'd3,
      REQ_IDLE       = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      CFG_PULSE_TICKS = 3'd0,
      CFG_DELAY_TICKS = 3'd1,
      CFG_DELAY_MODE  = 3'd2,
      CFG_STEP_INVERT = 3'd3,
      CFG_DIR_INVERT  = 3'd4
   } cfg_reg_type;

endpackage

FILE: src/step_pulse_and_segment_timer_core.sv
// Step/direction pulse engine with one-shot pulse timer and segment timer.
// Depends on spst_pkg and assert_macros.svh.
//
// Usage:
//   req channel: one request per item; req_tuser holds the request kind
//   (tick, pulse start, set period, wake up, go idle). rsp channel: one
//   result per request, carrying the pin levels and timer status after it.
//   csr port: APB-style register file, five registers at byte address 4*i.
//   The result of a request is registered in the output register as the
//   request is accepted. Throughput: one request per cycle while the output
//   register is free; the state update for a request is a single pass through
//   the next-state logic, closed by the 32-bit segment counter compare and increment.
//   Stall: while a result waits in the output register and rsp_tready is
//   low, req_tready drops and only CSR writes change state; a result taken in
//   the same cycle frees the register for the next request.
//   Reset: synchronous, active high. Registers return to pulse width 120,
//   delay 0, delay mode off, no inversion; pins low, both timers stopped.
//   Registers are to be written only while no request is in flight; the block does not enforce it.
`include "assert_macros.svh"

module step_pulse_and_segment_timer_core #(
   parameter int unsigned NUM_AXES       = spst_pkg::NUM_AXES_DEF,
   parameter int unsigned MIN_SEG_PERIOD = spst_pkg::MIN_SEG_PERIOD_DEF,
   parameter logic [31:0] WAKE_PERIOD    = spst_pkg::WAKE_PERIOD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] step_bits, [7:4] dir_bits, [8] dir_update, [9] pin_clear,
   // [41:10] period_cycles, [47:42] zero
   input  logic [47:0] req_tdata,
   // [2:0] req_type
   input  logic [2:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] step_pins, [7:4] dir_pins, [8] segment_irq, [9] pulse_active,
   // [10] delaying, [15:11] zero
   output logic [15:0] rsp_tdata,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [3:0]  AXIS_MASK   = 4'((1 << NUM_AXES) - 1);
   localparam logic [31:0] MIN_SEG     = 32'(MIN_SEG_PERIOD);
   localparam logic [31:0] WAKE_CLAMPED = (WAKE_PERIOD < MIN_SEG) ? MIN_SEG : WAKE_PERIOD;

   // configuration registers
   logic [15:0] pulse_ticks_ff, delay_ticks_ff;
   logic        delay_mode_ff;
   logic [3:0]  step_invert_ff, dir_invert_ff;

   // engine state
   logic [3:0]  step_level_ff, step_level_in;
   logic [3:0]  dir_level_ff, dir_level_in;
   logic [15:0] pulse_count_ff, pulse_count_in;
   logic [15:0] pulse_period_ff, pulse_period_in;
   logic        pulse_running_ff, pulse_running_in;
   logic        pulse_deferring_ff, pulse_deferring_in;
   logic [3:0]  pending_steps_ff, pending_steps_in;
   logic [31:0] seg_count_ff, seg_count_in;
   logic [31:0] seg_period_ff, seg_period_in;
   logic        seg_running_ff, seg_running_in;
   logic        irq_in;

   // output register
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;

   logic        req_accept, cfg_write;
   logic        cfg_timing_write;
   logic [3:0]  steps, dirs;
   logic        changed, clear_req;
   logic [31:0] period_req;
   logic [15:0] cfg_pulse_val;
   logic [15:0] cfg_period_val;
   spst_pkg::cfg_reg_type cfg_idx;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign steps      = req_tdata[3:0] & AXIS_MASK;
   assign dirs       = req_tdata[7:4] & AXIS_MASK;
   assign changed    = req_tdata[8];
   assign clear_req  = req_tdata[9];
   assign period_req = req_tdata[41:10];

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_idx    = spst_pkg::cfg_reg_type'(csr_paddr[4:2]);
   assign cfg_pulse_val = (csr_pwdata[15:0] < spst_pkg::PULSE_FLOOR) ?
                          spst_pkg::PULSE_FLOOR : csr_pwdata[15:0];
   // timing register writes drop a pending deferral and reload the one-shot period
   assign cfg_timing_write = cfg_write && (cfg_idx inside {spst_pkg::CFG_PULSE_TICKS,
                             spst_pkg::CFG_DELAY_TICKS, spst_pkg::CFG_DELAY_MODE});
   assign cfg_period_val = (cfg_idx == spst_pkg::CFG_PULSE_TICKS) ? cfg_pulse_val :
                           pulse_ticks_ff;

   always_comb begin
      csr_prdata = '0;
      case (cfg_idx)
         spst_pkg::CFG_PULSE_TICKS: csr_prdata = {16'd0, pulse_ticks_ff};
         spst_pkg::CFG_DELAY_TICKS: csr_prdata = {16'd0, delay_ticks_ff};
         spst_pkg::CFG_DELAY_MODE:  csr_prdata = {31'd0, delay_mode_ff};
         spst_pkg::CFG_STEP_INVERT: csr_prdata = {28'd0, step_invert_ff};
         spst_pkg::CFG_DIR_INVERT:  csr_prdata = {28'd0, dir_invert_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // next state for one request
   always_comb begin
      step_level_in      = step_level_ff;
      dir_level_in       = dir_level_ff;
      pulse_count_in     = pulse_count_ff;
      pulse_period_in    = pulse_period_ff;
      pulse_running_in   = pulse_running_ff;
      pulse_deferring_in = pulse_deferring_ff;
      pending_steps_in   = pending_steps_ff;
      seg_count_in       = seg_count_ff;
      seg_period_in      = seg_period_ff;
      seg_running_in     = seg_running_ff;
      irq_in             = 1'b0;

      case (spst_pkg::req_kind_type'(req_tuser))
         spst_pkg::REQ_TICK: begin
            if (pulse_running_ff) begin
               if (pulse_count_ff != pulse_period_ff) begin
                  pulse_count_in = pulse_count_ff + 16'd1;
               end else if (pulse_deferring_ff) begin
                  // delay over: assert the held step and time the pulse
                  pulse_deferring_in = 1'b0;
                  step_level_in      = (pending_steps_ff ^ step_invert_ff) & AXIS_MASK;
                  pulse_period_in    = pulse_ticks_ff;
                  pulse_count_in     = '0;
               end else begin
                  pulse_running_in = 1'b0;
                  step_level_in    = step_invert_ff & AXIS_MASK;
               end
            end
            if (seg_running_ff) begin
               if (seg_count_ff == seg_period_ff) begin
                  seg_count_in = '0;
                  irq_in       = 1'b1;
               end else begin
                  seg_count_in = seg_count_ff + 32'd1;
               end
            end
         end
         spst_pkg::REQ_PULSE: begin
            if (changed) begin
               dir_level_in = (dirs ^ dir_invert_ff) & AXIS_MASK;
            end
            if (changed && delay_mode_ff) begin
               if (steps != 4'd0) begin
                  pending_steps_in   = steps;
                  pulse_deferring_in = 1'b1;
                  pulse_period_in    = delay_ticks_ff;
                  pulse_count_in     = '0;
                  pulse_running_in   = 1'b1;
               end
            end else if (steps != 4'd0) begin
               step_level_in    = (steps ^ step_invert_ff) & AXIS_MASK;
               pulse_count_in   = '0;
               pulse_running_in = 1'b1;
            end
         end
         spst_pkg::REQ_SET_PERIOD: begin
            seg_period_in = (period_req < MIN_SEG) ? MIN_SEG : period_req;
         end
         spst_pkg::REQ_WAKE: begin
            seg_period_in  = WAKE_CLAMPED;
            seg_count_in   = '0;
            seg_running_in = 1'b1;
         end
         spst_pkg::REQ_IDLE: begin
            seg_running_in = 1'b0;
            if (clear_req) begin
               step_level_in = step_invert_ff & AXIS_MASK;
               dir_level_in  = dir_invert_ff & AXIS_MASK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ticks_ff     <= spst_pkg::PULSE_TICKS_RST;
         delay_ticks_ff     <= '0;
         delay_mode_ff      <= 1'b0;
         step_invert_ff     <= '0;
         dir_invert_ff      <= '0;
         step_level_ff      <= '0;
         dir_level_ff       <= '0;
         pulse_count_ff     <= '0;
         pulse_period_ff    <= spst_pkg::PULSE_TICKS_RST;
         pulse_running_ff   <= 1'b0;
         pulse_deferring_ff <= 1'b0;
         pending_steps_ff   <= '0;
         seg_count_ff       <= '0;
         seg_period_ff      <= '0;
         seg_running_ff     <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (req_accept) begin
            step_level_ff      <= step_level_in;
            dir_level_ff       <= dir_level_in;
            pulse_count_ff     <= pulse_count_in;
            pulse_running_ff   <= pulse_running_in;
            pending_steps_ff   <= pending_steps_in;
            seg_count_ff       <= seg_count_in;
            seg_period_ff      <= seg_period_in;
            seg_running_ff     <= seg_running_in;
            rsp_valid_ff       <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cfg_timing_write) begin
            pulse_deferring_ff <= 1'b0;
            pulse_period_ff    <= cfg_period_val;
         end else if (req_accept) begin
            pulse_deferring_ff <= pulse_deferring_in;
            pulse_period_ff    <= pulse_period_in;
         end

         if (cfg_write) begin
            case (cfg_idx)
               spst_pkg::CFG_PULSE_TICKS: pulse_ticks_ff <= cfg_pulse_val;
               spst_pkg::CFG_DELAY_TICKS: delay_ticks_ff <= csr_pwdata[15:0];
               spst_pkg::CFG_DELAY_MODE:  delay_mode_ff  <= csr_pwdata[0];
               spst_pkg::CFG_STEP_INVERT: step_invert_ff <= csr_pwdata[3:0] & AXIS_MASK;
               spst_pkg::CFG_DIR_INVERT:  dir_invert_ff  <= csr_pwdata[3:0] & AXIS_MASK;
               default: begin
               end
            endcase
         end
      end
   end

   // result register holds the state as left by the accepted request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= {5'd0, pulse_deferring_in, pulse_running_in, irq_in,
                         dir_level_in, step_level_in};
      end
   end

   `ASSERT_IMPLIES(a_defer_needs_run, clock, reset, pulse_deferring_ff, pulse_running_ff)
   `ASSERT_IMPLIES(a_irq_wraps_count, clock, reset, rsp_valid_ff && rsp_data_ff[8],
                   seg_count_ff == 32'd0)
   `ASSERT_IMPLIES(a_stall_blocks_req, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready)
   `ASSERT_ALWAYS(a_absent_axes_low, clock, reset,
                  ((step_level_ff | dir_level_ff) & ~AXIS_MASK) == 4'd0)

endmodule
